### rtl/core/ise_pkg.sv
// ise_pkg: shared types and constants of the insertion sort engine
// no dependencies; used by the interfaces, the cell and the top level
`default_nettype none

package ise_pkg;

   localparam int ISE_DEPTH = 16;
   localparam int ISE_VALUE_WIDTH = 32;

   typedef logic signed [ISE_VALUE_WIDTH-1:0] value_type;

   // controller state: loading a set or draining it
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic drain_en;
   } cell_ctl_type;

endpackage

`default_nettype wire

### rtl/core/ise_req_if.sv
// ise_req_if: request channel of the insertion sort engine
// depends on ise_pkg
`default_nettype none

interface ise_req_if
   import ise_pkg::*;
   ();
   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      is_last;

   modport source (output valid, output sample_value, output is_last, input ready);
   modport sink   (input valid, input sample_value, input is_last, output ready);
endinterface

`default_nettype wire

### rtl/core/ise_rsp_if.sv
// ise_rsp_if: response channel of the insertion sort engine
// depends on ise_pkg
`default_nettype none

interface ise_rsp_if
   import ise_pkg::*;
   ();
   logic      valid;
   logic      ready;
   value_type sorted_value;
   logic      final_item;
   logic      overflowed;

   modport source (output valid, output sorted_value, output final_item,
                   output overflowed, input ready);
   modport sink   (input valid, input sorted_value, input final_item,
                   input overflowed, output ready);
endinterface

`default_nettype wire

### rtl/core/ise_cell.sv
// ise_cell: one slot of the sorting chain, holding a value and its valid bit
// depends on ise_pkg
`default_nettype none

module ise_cell
   import ise_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  value_type    sample_value,
   input  value_type    left_value,
   input  logic         left_valid,
   input  logic         left_greater,
   input  value_type    right_value,
   input  logic         right_valid,
   output value_type    value,
   output logic         valid,
   output logic         greater
);

   value_type value_ff, value_in;
   logic      valid_ff, valid_in;

   assign greater = valid_ff && (value_ff > sample_value);
   assign value   = value_ff;
   assign valid   = valid_ff;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.drain_en) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctl.insert_en) begin
         if (left_greater) begin
            // make room: take the neighbour's word
            value_in = left_value;
            valid_in = 1'b1;
         end else if (left_valid && (greater || !valid_ff)) begin
            value_in = sample_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/insertion_sort_engine.sv
// insertion_sort_engine: top level, a chain of ise_cell slots and the load/drain control
// depends on ise_pkg, ise_req_if, ise_rsp_if and ise_cell
`default_nettype none

// Stable streaming insertion sorter. While a set is loading, one word is taken
// on every cycle: the word is broadcast along a chain of DEPTH cells, each cell
// compares it with its own entry and the cells above the insertion point shift
// up by one in the same cycle, so equal values keep arrival order. A word that
// arrives with the chain full is dropped and the set is marked overflowed. The
// word flagged is_last is inserted (or dropped) as well, then the chain drains
// from its bottom cell, one sorted word per cycle of rsp handshake, pausing
// while the receiver holds rsp ready low. The request side is held off while
// draining and reopens in the cycle after the final word is taken. Reset clears
// the state, the overflow mark and the valid bits of the cells, but not the cell
// values.
module insertion_sort_engine
   import ise_pkg::*;
#(
   parameter int DEPTH = ISE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   ise_req_if.sink   req_port,
   ise_rsp_if.source rsp_port
);

   state_type    state_ff, state_in;
   logic         overflow_ff, overflow_in;
   cell_ctl_type ctl;

   value_type        cell_value [DEPTH];
   logic [DEPTH-1:0] cell_valid;
   logic [DEPTH-1:0] cell_greater;

   logic req_accept;
   logic rsp_accept;
   logic full;

   assign full       = cell_valid[DEPTH-1];
   assign req_accept = req_port.valid && req_port.ready;
   assign rsp_accept = rsp_port.valid && rsp_port.ready;

   // cells: bottom cell sees an always-valid, never-greater neighbour on its left
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      value_type left_value, right_value;
      logic      left_valid, left_greater, right_valid;

      if (i == 0) begin : g_bottom
         assign left_value   = req_port.sample_value;
         assign left_valid   = 1'b1;
         assign left_greater = 1'b0;
      end else begin : g_inner
         assign left_value   = cell_value[i-1];
         assign left_valid   = cell_valid[i-1];
         assign left_greater = cell_greater[i-1];
      end

      if (i == DEPTH-1) begin : g_top
         assign right_value = cell_value[i];
         assign right_valid = 1'b0;
      end else begin : g_below
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end

      ise_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .sample_value (req_port.sample_value),
         .left_value   (left_value),
         .left_valid   (left_valid),
         .left_greater (left_greater),
         .right_value  (right_value),
         .right_valid  (right_valid),
         .value        (cell_value[i]),
         .valid        (cell_valid[i]),
         .greater      (cell_greater[i])
      );
   end

   // response word comes straight from the bottom cell register
   assign rsp_port.sorted_value = cell_value[0];
   assign rsp_port.final_item   = !cell_valid[1];
   assign rsp_port.overflowed   = overflow_ff;

   // load/drain control
   always_comb begin
      state_in      = state_ff;
      overflow_in   = overflow_ff;
      ctl.insert_en = 1'b0;
      ctl.drain_en  = 1'b0;
      req_port.ready = 1'b0;
      rsp_port.valid = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            // ready is high throughout loading, so valid alone marks a taken word
            req_port.ready = 1'b1;
            if (req_port.valid) begin
               // a full chain drops the word and marks the set
               ctl.insert_en = !full;
               if (full) begin
                  overflow_in = 1'b1;
               end
               if (req_port.is_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            // valid is high throughout draining, so ready alone marks a taken word
            rsp_port.valid = 1'b1;
            ctl.drain_en   = rsp_port.ready;
            if (rsp_port.ready && rsp_port.final_item) begin
               state_in    = ST_LOAD;
               overflow_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         overflow_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         overflow_ff <= overflow_in;
      end
   end

   // occupied cells always form a run from the bottom
   a_valid_run: assert property (@(posedge clock) disable iff (reset)
      $onehot({1'b0, cell_valid} + {{DEPTH{1'b0}}, 1'b1}))
      else $error("cell valid bits not contiguous");

   // bottom two cells stay in order
   a_bottom_order: assert property (@(posedge clock) disable iff (reset)
      cell_valid[1] |-> !(cell_value[0] > cell_value[1]))
      else $error("bottom cells out of order");

   // a last word always leaves at least one word to drain
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_port.is_last) |=> (rsp_port.valid && cell_valid[0]))
      else $error("set closed with nothing to drain");

   // the final word empties the chain and clears the overflow mark
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_port.final_item) |=> (cell_valid == '0 && !overflow_ff))
      else $error("chain not empty after final word");

endmodule

`default_nettype wire

### tb/tb_insertion_sort_engine.sv
// tb_insertion_sort_engine: self-checking bench for the streaming stable insertion sorter
// depends on ise_pkg, ise_req_if, ise_rsp_if and the insertion_sort_engine rtl
// directed sets, then random sets of random length checked word by word against a shadow sorter

module tb_insertion_sort_engine
   import ise_pkg::*;
   ();
   timeunit 1ns;
   timeprecision 1ps;

   // limits and stall lengths
   localparam int        RANDOM_WORDS = 500;
   localparam int        LONG_HOLD    = 300;
   localparam int        STALL_LIMIT  = 2000;
   localparam int        DRAIN_SLACK  = 20;
   localparam value_type VALUE_MIN    = {1'b1, {(ISE_VALUE_WIDTH-1){1'b0}}};
   localparam value_type VALUE_MAX    = {1'b0, {(ISE_VALUE_WIDTH-1){1'b1}}};

   // one word waiting to be offered, with its pacing
   typedef struct {
      value_type value;
      logic      is_last;
      int        gap_before;   // idle cycles before it is offered
      logic      wait_idle;    // hold it back until every sorted word has come out
      logic      hold_sink;    // start the long receiver hold when it is offered
   } pending_word_type;

   // one sorted word as it should leave the block
   typedef struct packed {
      value_type sorted_value;
      logic      final_item;
      logic      overflowed;
   } sorted_word_type;

   logic clock = 1'b0;
   logic reset;

   ise_req_if req_bus ();
   ise_rsp_if rsp_bus ();

   insertion_sort_engine #(
      .DEPTH(ISE_DEPTH)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pending_word_type pending_words[$];
   sorted_word_type  expected_words[$];

   // shadow copy of the sorter state
   value_type shadow_store [ISE_DEPTH];
   int        shadow_count;
   logic      shadow_overflow;

   // handshake bookkeeping shared between the driver, the sink and the monitor
   logic offer_active;
   logic req_took;
   int   gap_count;
   int   hold_requests;
   int   holds_served;
   int   stall_left;
   int   steady_left;
   int   idle_cycles;
   int   mismatch_count;

   // stable insertion: the new word lands after every entry equal to it,
   // a word that meets a full store is dropped and marks the set overflowed,
   // and a last word releases the whole store in ascending order
   function automatic void insert_and_emit(value_type v, logic is_last);
      int              pos;
      sorted_word_type w;
      if (shadow_count >= ISE_DEPTH) begin
         shadow_overflow = 1'b1;
      end else begin
         pos = shadow_count;
         while (pos > 0 && shadow_store[pos-1] > v) begin
            shadow_store[pos] = shadow_store[pos-1];
            pos--;
         end
         shadow_store[pos] = v;
         shadow_count++;
      end
      if (is_last) begin
         for (int k = 0; k < shadow_count; k++) begin
            w.sorted_value = shadow_store[k];
            w.final_item   = (k == shadow_count - 1);
            w.overflowed   = shadow_overflow;
            expected_words.push_back(w);
         end
         shadow_count    = 0;
         shadow_overflow = 1'b0;
      end
   endfunction

   function automatic void add_word(value_type v, logic is_last, int gap,
                                    logic wait_idle, logic hold_sink);
      pending_word_type p;
      p.value      = v;
      p.is_last    = is_last;
      p.gap_before = gap;
      p.wait_idle  = wait_idle;
      p.hold_sink  = hold_sink;
      pending_words.push_back(p);
   endfunction

   // value styles: full 32-bit random, a narrow band full of ties, or the extremes
   function automatic value_type pick_value(int style);
      int r;
      r = $urandom_range(0, 99);
      if (r < 4 || style == 2) begin
         case ($urandom_range(0, 5))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return '0;
            3:       return '1;
            4:       return value_type'(1);
            default: return value_type'($urandom);
         endcase
      end
      if (style == 1) return value_type'($urandom_range(0, 6)) - 3;
      return value_type'($urandom);
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(logic burst);
      int r;
      if (burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver: offers the queued words at the falling edge
   always @(negedge clock) begin : drive_req
      pending_word_type cur;
      if (!reset) begin
         if (offer_active && req_took) offer_active = 1'b0;
         if (!offer_active && pending_words.size() > 0) begin
            if (gap_count < pending_words[0].gap_before) begin
               gap_count++;
            end else if (!(pending_words[0].wait_idle && expected_words.size() > 0)) begin
               cur = pending_words.pop_front();
               if (cur.hold_sink) hold_requests++;
               offer_active = 1'b1;
               gap_count    = 0;
               req_bus.sample_value <= cur.value;
               req_bus.is_last      <= cur.is_last;
            end
         end
         req_bus.valid <= offer_active;
      end
   end

   // result sink: random stalls, steady stretches and the one long hold
   always @(negedge clock) begin : drive_rsp_ready
      int r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            stall_left   = LONG_HOLD;
         end else if (stall_left > 0) begin
            stall_left--;
         end else if (steady_left > 0) begin
            steady_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 2) steady_left = $urandom_range(40, 150);
            else if (r < 5) stall_left = $urandom_range(10, 40);
            else if (r < 25) stall_left = $urandom_range(1, 3);
         end
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // monitor: predicts on every accepted request word, checks every accepted sorted word
   always @(posedge clock) begin : watch_ports
      sorted_word_type want;
      req_took = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            req_took    = 1'b1;
            idle_cycles = 0;
            insert_and_emit(req_bus.sample_value, req_bus.is_last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            idle_cycles = 0;
            if (expected_words.size() == 0) begin
               $error("unexpected sorted word %0d with nothing outstanding",
                      rsp_bus.sorted_value);
               mismatch_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_bus.sorted_value);
                  mismatch_count++;
               end
               if (rsp_bus.final_item !== want.final_item) begin
                  $error("final_item: expected %0b, got %0b",
                         want.final_item, rsp_bus.final_item);
                  mismatch_count++;
               end
               if (rsp_bus.overflowed !== want.overflowed) begin
                  $error("overflowed: expected %0b, got %0b",
                         want.overflowed, rsp_bus.overflowed);
                  mismatch_count++;
               end
            end
         end
         // nothing moved on either side for far too long
         if (idle_cycles >= STALL_LIMIT) begin
            $display("** insertion_sort_engine: FAILED **");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int   added;
      int   set_no;
      int   len;
      int   style;
      logic burst;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.sample_value = '0;
      req_bus.is_last      = 1'b0;
      rsp_bus.ready        = 1'b0;
      offer_active         = 1'b0;
      req_took             = 1'b0;
      gap_count            = 0;
      hold_requests        = 0;
      holds_served         = 0;
      stall_left           = 0;
      steady_left          = 0;
      idle_cycles          = 0;
      mismatch_count       = 0;
      shadow_count         = 0;
      shadow_overflow      = 1'b0;

      // directed: single-word sets at both extremes
      add_word(VALUE_MIN, 1'b1, 0, 1'b0, 1'b0);
      add_word(VALUE_MAX, 1'b1, 0, 1'b0, 1'b0);
      // extremes mixed, with a repeated minimum closing the set
      add_word(VALUE_MAX, 1'b0, 0, 1'b0, 1'b0);
      add_word(VALUE_MIN, 1'b0, 0, 1'b0, 1'b0);
      add_word('0, 1'b0, 1, 1'b0, 1'b0);
      add_word('1, 1'b0, 0, 1'b0, 1'b0);
      add_word(value_type'(1), 1'b0, 0, 1'b0, 1'b0);
      add_word(VALUE_MIN, 1'b1, 0, 1'b0, 1'b0);
      // store filled with ties, then a last word that meets a full store and is dropped
      for (int k = 0; k < ISE_DEPTH; k++)
         add_word(value_type'((k * 7) % 5) - 2, 1'b0, 0, 1'b0, 1'b0);
      add_word(VALUE_MIN, 1'b1, 0, 1'b0, 1'b0);

      // random sets: mostly within capacity, some exactly full, some overflowing
      added  = 0;
      set_no = 0;
      while (added < RANDOM_WORDS) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = ISE_DEPTH;
            2:       len = $urandom_range(ISE_DEPTH + 1, ISE_DEPTH + 8);
            default: len = $urandom_range(2, ISE_DEPTH);
         endcase
         style = $urandom_range(0, 2);
         burst = (set_no == 9) || ($urandom_range(0, 9) < 3);
         for (int k = 0; k < len; k++) begin
            // set 8 ends with the long receiver hold; set 9 keeps pushing behind it,
            // and sets 20 and 40 start only once the block has fully drained
            add_word(pick_value(style), k == len - 1, pick_gap(burst),
                     (k == 0) && (set_no == 20 || set_no == 40),
                     (k == len - 1) && (set_no == 8));
         end
         added += len;
         set_no++;
      end

      repeat (9) @(negedge clock);
      reset = 1'b0;

      while (pending_words.size() > 0 || offer_active || expected_words.size() > 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** insertion_sort_engine: PASSED **");
      end else begin
         $display("** insertion_sort_engine: FAILED **");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/ise_pkg.sv
rtl/core/ise_req_if.sv
rtl/core/ise_rsp_if.sv
rtl/core/ise_cell.sv
rtl/core/insertion_sort_engine.sv
tb/tb_insertion_sort_engine.sv
